// ----- design/tpc_pkg.sv -----
// Shared types, constants and register codes of the turn PID controller.
`default_nettype none

package tpc_pkg;

  // Heading samples and targets, degrees with 8 fractional bits.
  localparam int HEADING_WIDTH   = 20;
  // Control period in milliseconds, default for the top-level parameter.
  localparam int TICK_MS_DEFAULT = 10;

  localparam int GAIN_WIDTH   = 16;
  localparam int LIMIT_WIDTH  = 15;
  localparam int TOL_WIDTH    = 16;
  localparam int RANGE_WIDTH  = 18;
  localparam int INTEG_WIDTH  = 18;
  localparam int MS_WIDTH     = 18;
  localparam int POWER_WIDTH  = 16;

  // Time budget rules and the integral step of 0.01 in 16 fractional bits.
  localparam logic [MS_WIDTH-1:0] MS_MAX        = '1;
  localparam logic [MS_WIDTH-1:0] BUDGET_MIN_MS = 18'd700;
  localparam int BUDGET_MS_PER_DEG = 27;
  localparam int BUDGET_BIG_ERR    = 20 * 256;
  localparam int INTEG_STEP        = 655;

  // Configuration port.
  localparam int REG_ADDR_WIDTH = 5;
  localparam int REG_DATA_WIDTH = 32;
  localparam logic [2:0] REG_KP_GAIN         = 3'd0;
  localparam logic [2:0] REG_KI_GAIN         = 3'd1;
  localparam logic [2:0] REG_KD_GAIN         = 3'd2;
  localparam logic [2:0] REG_POWER_LIMIT     = 3'd3;
  localparam logic [2:0] REG_ERROR_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_RATE_TOLERANCE  = 3'd5;
  localparam logic [2:0] REG_INTEGRAL_START  = 3'd6;
  localparam logic [2:0] REG_INTEGRAL_RANGE  = 3'd7;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                             operation;
    logic signed [HEADING_WIDTH-1:0] target;
    logic signed [HEADING_WIDTH-1:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [POWER_WIDTH-1:0] drive_power;
    logic                          finished;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]  kp_gain;
    logic [GAIN_WIDTH-1:0]  ki_gain;
    logic [GAIN_WIDTH-1:0]  kd_gain;
    logic [LIMIT_WIDTH-1:0] power_limit;
    logic [TOL_WIDTH-1:0]   error_tolerance;
    logic [TOL_WIDTH-1:0]   rate_tolerance;
    logic [TOL_WIDTH-1:0]   integral_start;
    logic [RANGE_WIDTH-1:0] integral_range;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/turn_pid_controller.sv -----
// Top level of the turn PID controller: turn state, control pipeline and result register.
//
// Usage: configure the gains, the power limit and the tolerances through the APB-style
// port while the block is idle. Items arrive on item/item_valid/item_stall. A start item
// latches the target and sets up the turn and its time budget; it returns zero power, with
// finished high when the heading is already on target. Each tick item carries a heading
// sample and returns the clamped drive power, with finished high on the tick that ends the
// turn. Ticks outside a turn return zero power with finished high.
// A result is presented on result/result_valid after its item passes the input register,
// the operand register and the stages below. Throughput: one item per cycle unless stalled,
// set by the turn state being updated as an item leaves the first stage; the three gain
// products, the sum and the rounding and clamp each take one further register stage.
// When the receiver holds result_stall, the result register keeps its item and the
// stages behind it fill up; item_stall rises only once every stage holds an item.
// Reset (rst, synchronous) clears the turn state, empties the pipeline and restores the
// register defaults.
`default_nettype none

module turn_pid_controller #(
  parameter int TICK_MS = tpc_pkg::TICK_MS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Item channel.
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire tpc_pkg::in_item_t                   item,
  // Result channel.
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output tpc_pkg::out_item_t                       result,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tpc_pkg::REG_ADDR_WIDTH-1:0]  paddr,
  input  wire logic [tpc_pkg::REG_DATA_WIDTH-1:0]  pwdata,
  output logic      [tpc_pkg::REG_DATA_WIDTH-1:0]  prdata,
  output logic                                     pready
);

  localparam int HW     = tpc_pkg::HEADING_WIDTH;
  localparam int EW     = HW + 1;
  localparam int DW     = HW + 2;
  localparam int IW     = tpc_pkg::INTEG_WIDTH;
  localparam int MW     = tpc_pkg::MS_WIDTH;
  localparam int PWR_W  = tpc_pkg::POWER_WIDTH;
  localparam int GW     = tpc_pkg::GAIN_WIDTH + 1;
  localparam int KP_W   = GW + EW;
  localparam int KD_W   = GW + DW;
  localparam int KI_W   = GW + IW;
  localparam int SUM_W  = KD_W + 1;
  localparam int TR_W   = SUM_W - 8;
  localparam int CMP_W  = (DW > tpc_pkg::TOL_WIDTH) ? DW : tpc_pkg::TOL_WIDTH;
  localparam int BP_W   = EW + 5;
  localparam int BQ_W   = BP_W - 8;
  localparam int BC_W   = (BQ_W > MW) ? BQ_W : MW;

  tpc_pkg::cfg_t cfg;

  tpc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Turn state.
  logic signed [HW-1:0] target_heading;
  logic signed [EW-1:0] previous_error;
  logic signed [IW-1:0] integral_sum;
  logic [MW-1:0]        elapsed_ms;
  logic [MW-1:0]        time_budget_ms;
  logic                 running;

  // Pipeline occupancy and readiness, from the result register back to the input.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic r_out, r4, r3, r2, r1;
  logic adv1;

  assign r_out      = !result_valid || !result_stall;
  assign r4         = !s4_valid || r_out;
  assign r3         = !s3_valid || r4;
  assign r2         = !s2_valid || r3;
  assign r1         = !s1_valid || r2;
  assign item_stall = !r1;
  assign adv1       = s1_valid && r2;

  // Stage 1: input register.
  tpc_pkg::in_item_t s1_item;

  // Error, error change and their magnitudes.
  logic                 is_start;
  logic signed [HW-1:0] tgt_sel;
  logic signed [EW-1:0] err;
  logic signed [DW-1:0] diff;
  logic [EW-1:0]        err_mag;
  logic [DW-1:0]        diff_mag;
  logic                 err_zero;

  assign is_start = (s1_item.operation == tpc_pkg::OP_START);
  assign tgt_sel  = is_start ? s1_item.target : target_heading;
  assign err      = {tgt_sel[HW-1], tgt_sel} - {s1_item.heading[HW-1], s1_item.heading};
  assign diff     = {err[EW-1], err} - {previous_error[EW-1], previous_error};
  assign err_mag  = err[EW-1] ? -err : err;
  assign diff_mag = diff[DW-1] ? -diff : diff;
  assign err_zero = (err == '0);

  // Time budget of a new turn: a floor for small errors, else a rate per degree.
  logic [BP_W-1:0]  budget_prod;
  logic [BC_W-1:0]  budget_q;
  logic [MW-1:0]    budget_new;
  logic             big_err;

  assign big_err     = CMP_W'(err_mag) >= CMP_W'(tpc_pkg::BUDGET_BIG_ERR);
  assign budget_prod = BP_W'(err_mag) * BP_W'(tpc_pkg::BUDGET_MS_PER_DEG);
  assign budget_q    = BC_W'(budget_prod[BP_W-1:8]);
  always_comb begin
    if (!big_err) begin
      budget_new = tpc_pkg::BUDGET_MIN_MS;
    end else if (budget_q > BC_W'(tpc_pkg::MS_MAX)) begin
      budget_new = tpc_pkg::MS_MAX;
    end else begin
      budget_new = budget_q[MW-1:0];
    end
  end

  // Elapsed time with saturation, and the finish decision of a tick.
  logic [MW:0]   elapsed_sum;
  logic [MW-1:0] elapsed_new;
  logic          tick_fin;

  assign elapsed_sum = {1'b0, elapsed_ms} + (MW+1)'(TICK_MS);
  assign elapsed_new = elapsed_sum[MW] ? tpc_pkg::MS_MAX : elapsed_sum[MW-1:0];
  assign tick_fin    = ((CMP_W'(err_mag) < CMP_W'(cfg.error_tolerance))
                        && (CMP_W'(diff_mag) <= CMP_W'(cfg.rate_tolerance)))
                       || (elapsed_new > time_budget_ms);

  // Integral step near the target, saturated, then cleared on a zero error or a sign change.
  logic [IW-1:0]        integ_mag;
  logic signed [IW:0]   integ_ext;
  logic signed [IW:0]   integ_step;
  logic signed [IW-1:0] integ_sat;
  logic signed [IW-1:0] integ_acc;
  logic signed [IW-1:0] integ_new;
  logic                 integ_on;
  logic                 sign_break;

  assign integ_mag = integral_sum[IW-1] ? -integral_sum : integral_sum;
  assign integ_ext = {integral_sum[IW-1], integral_sum};
  assign integ_on  = (integ_mag < cfg.integral_range)
                     && (CMP_W'(err_mag) < CMP_W'(cfg.integral_start));
  always_comb begin
    if (err_zero) begin
      integ_step = integ_ext;
    end else if (err[EW-1]) begin
      integ_step = integ_ext - (IW+1)'(tpc_pkg::INTEG_STEP);
    end else begin
      integ_step = integ_ext + (IW+1)'(tpc_pkg::INTEG_STEP);
    end
  end
  always_comb begin
    if (integ_step[IW] != integ_step[IW-1]) begin
      integ_sat = integ_step[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_sat = integ_step[IW-1:0];
    end
  end
  assign integ_acc  = integ_on ? integ_sat : integral_sum;
  assign sign_break = err_zero || (previous_error == '0)
                      || (err[EW-1] != previous_error[EW-1]);
  assign integ_new  = sign_break ? '0 : integ_acc;

  // Stage 2 payload: operands of the products and the result flags.
  logic signed [EW-1:0] s2_err;
  logic signed [DW-1:0] s2_diff;
  logic signed [IW-1:0] s2_integ;
  logic                 s2_zero;
  logic                 s2_fin;

  // Stage 3 payload: the three gain products.
  logic signed [KP_W-1:0] s3_kp;
  logic signed [KD_W-1:0] s3_kd;
  logic signed [KI_W-1:0] s3_ki;
  logic                   s3_zero;
  logic                   s3_fin;

  // Stage 4 payload: the sum of the terms.
  logic signed [SUM_W-1:0] s4_sum;
  logic                    s4_zero;
  logic                    s4_fin;

  // Integral term truncated toward zero to 8 fractional bits, then the sum.
  logic [KI_W-1:0]          ki_adj;
  logic signed [KI_W-9:0]   ki_trunc;
  logic signed [SUM_W-1:0]  sum_next;

  assign ki_adj   = s3_ki + (s3_ki[KI_W-1] ? KI_W'(255) : KI_W'(0));
  assign ki_trunc = ki_adj[KI_W-1:8];
  assign sum_next = SUM_W'(s3_kp) + SUM_W'(s3_kd) + SUM_W'(ki_trunc);

  // Power: the sum truncated toward zero and clamped to the limit.
  logic [SUM_W-1:0]        sum_adj;
  logic signed [TR_W-1:0]  power_raw;
  logic signed [TR_W-1:0]  lim_pos;
  logic signed [TR_W-1:0]  lim_neg;
  logic signed [TR_W-1:0]  power_clamp;
  tpc_pkg::out_item_t      result_next;

  assign sum_adj   = s4_sum + (s4_sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
  assign power_raw = sum_adj[SUM_W-1:8];
  assign lim_pos   = TR_W'({1'b0, cfg.power_limit});
  assign lim_neg   = -lim_pos;
  always_comb begin
    if (power_raw > lim_pos) begin
      power_clamp = lim_pos;
    end else if (power_raw < lim_neg) begin
      power_clamp = lim_neg;
    end else begin
      power_clamp = power_raw;
    end
    result_next.drive_power = s4_zero ? '0 : power_clamp[PWR_W-1:0];
    result_next.finished    = s4_fin;
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (r1) begin
        s1_valid <= item_valid;
      end
      if (r2) begin
        s2_valid <= s1_valid;
      end
      if (r3) begin
        s3_valid <= s2_valid;
      end
      if (r4) begin
        s4_valid <= s3_valid;
      end
      if (r_out) begin
        result_valid <= s4_valid;
      end
    end
  end

  // Turn state update as an item leaves the first stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      previous_error <= '0;
      integral_sum   <= '0;
      elapsed_ms     <= '0;
      time_budget_ms <= '0;
      running        <= 1'b0;
    end else if (adv1) begin
      if (is_start) begin
        target_heading <= s1_item.target;
        previous_error <= err;
        integral_sum   <= '0;
        elapsed_ms     <= '0;
        time_budget_ms <= budget_new;
        running        <= !err_zero;
      end else if (running) begin
        previous_error <= err;
        integral_sum   <= integ_new;
        elapsed_ms     <= elapsed_new;
        if (tick_fin) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    if (r1 && item_valid) begin
      s1_item <= item;
    end
    if (adv1) begin
      s2_err   <= err;
      s2_diff  <= diff;
      s2_integ <= integ_new;
      s2_zero  <= is_start || !running;
      if (is_start) begin
        s2_fin <= err_zero;
      end else begin
        s2_fin <= !running || tick_fin;
      end
    end
    if (r3 && s2_valid) begin
      s3_kp   <= $signed({1'b0, cfg.kp_gain}) * s2_err;
      s3_kd   <= $signed({1'b0, cfg.kd_gain}) * s2_diff;
      s3_ki   <= $signed({1'b0, cfg.ki_gain}) * s2_integ;
      s3_zero <= s2_zero;
      s3_fin  <= s2_fin;
    end
    if (r4 && s3_valid) begin
      s4_sum  <= sum_next;
      s4_zero <= s3_zero;
      s4_fin  <= s3_fin;
    end
    if (r_out && s4_valid) begin
      result <= result_next;
    end
  end

  // Checks on the turn state and the power clamp.
  logic signed [PWR_W:0] chk_power;
  logic signed [PWR_W:0] chk_limit;

  assign chk_power = {result.drive_power[PWR_W-1], result.drive_power};
  assign chk_limit = (PWR_W+1)'({1'b0, cfg.power_limit});

  a_power_in_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (chk_power <= chk_limit) && (chk_power >= -chk_limit))
    else $error("drive power outside the configured limit");

  a_stop_on_item: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(running)) |-> $past(adv1))
    else $error("turn ended without an item leaving the first stage");

  a_integral_cleared: assert property (@(posedge clk) disable iff (rst)
    (previous_error == '0) |-> (integral_sum == '0))
    else $error("integral held with a zero previous error");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (adv1 && is_start) |=> (elapsed_ms == '0) && (integral_sum == '0))
    else $error("start item did not clear elapsed time and integral");

endmodule

`default_nettype wire

// ----- design/tpc_cfg_regs.sv -----
// Configuration register file of the turn PID controller behind an APB-style port.
`default_nettype none

module tpc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tpc_pkg::REG_ADDR_WIDTH-1:0]  paddr,
  input  wire logic [tpc_pkg::REG_DATA_WIDTH-1:0]  pwdata,
  output logic      [tpc_pkg::REG_DATA_WIDTH-1:0]  prdata,
  output logic                                     pready,
  output tpc_pkg::cfg_t                            cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  // Registers sit on word addresses; pready is tied high, so the access phase has no wait states.
  assign reg_index = paddr[tpc_pkg::REG_ADDR_WIDTH-1:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  // Register writes, with the documented reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain         <= 16'd179;
      cfg.ki_gain         <= 16'd0;
      cfg.kd_gain         <= 16'd128;
      cfg.power_limit     <= 15'd25600;
      cfg.error_tolerance <= 16'd256;
      cfg.rate_tolerance  <= 16'd26;
      cfg.integral_start  <= 16'd15360;
      cfg.integral_range  <= 18'd65536;
    end else if (wr_en) begin
      case (reg_index)
        tpc_pkg::REG_KP_GAIN:         cfg.kp_gain         <= pwdata[15:0];
        tpc_pkg::REG_KI_GAIN:         cfg.ki_gain         <= pwdata[15:0];
        tpc_pkg::REG_KD_GAIN:         cfg.kd_gain         <= pwdata[15:0];
        tpc_pkg::REG_POWER_LIMIT:     cfg.power_limit     <= pwdata[14:0];
        tpc_pkg::REG_ERROR_TOLERANCE: cfg.error_tolerance <= pwdata[15:0];
        tpc_pkg::REG_RATE_TOLERANCE:  cfg.rate_tolerance  <= pwdata[15:0];
        tpc_pkg::REG_INTEGRAL_START:  cfg.integral_start  <= pwdata[15:0];
        tpc_pkg::REG_INTEGRAL_RANGE:  cfg.integral_range  <= pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    case (reg_index)
      tpc_pkg::REG_KP_GAIN:         prdata = 32'(cfg.kp_gain);
      tpc_pkg::REG_KI_GAIN:         prdata = 32'(cfg.ki_gain);
      tpc_pkg::REG_KD_GAIN:         prdata = 32'(cfg.kd_gain);
      tpc_pkg::REG_POWER_LIMIT:     prdata = 32'(cfg.power_limit);
      tpc_pkg::REG_ERROR_TOLERANCE: prdata = 32'(cfg.error_tolerance);
      tpc_pkg::REG_RATE_TOLERANCE:  prdata = 32'(cfg.rate_tolerance);
      tpc_pkg::REG_INTEGRAL_START:  prdata = 32'(cfg.integral_start);
      tpc_pkg::REG_INTEGRAL_RANGE:  prdata = 32'(cfg.integral_range);
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the turn PID controller: stimulus, predictor, checks and timeout.
`timescale 1ns / 1ps

module testbench;
  import tpc_pkg::*;

  localparam longint HEAD_MAX     = (longint'(1) << (HEADING_WIDTH - 1)) - 1;
  localparam longint HEAD_MIN     = -(longint'(1) << (HEADING_WIDTH - 1));
  localparam longint INTEG_TOP    = (longint'(1) << (INTEG_WIDTH - 1)) - 1;
  localparam longint INTEG_BOTTOM = -(longint'(1) << (INTEG_WIDTH - 1));
  localparam int     PHASE_ITEMS  = 130;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     HOLD_CYCLES  = 60;

  // Register values after reset, in the field order of cfg_t.
  localparam cfg_t RESET_CFG = {16'd179, 16'd0, 16'd128, 15'd25600,
                                16'd256, 16'd26, 16'd15360, 18'd65536};
  localparam cfg_t MAX_CFG   = {16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd25600,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 18'd131072};

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_item_t item;
  logic result_valid;
  logic result_stall;
  out_item_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [REG_ADDR_WIDTH-1:0] paddr;
  logic [REG_DATA_WIDTH-1:0] pwdata;
  logic [REG_DATA_WIDTH-1:0] prdata;
  logic pready;

  // Tracks the turn state and the register copy, and holds the expected drive results.
  class turn_tracker;
    cfg_t regs;
    longint target_hd;
    longint last_err;
    longint integ;
    longint elapsed;
    longint budget;
    bit turning;
    out_item_t expected_power[$];
    int mismatches;

    function new();
      regs = RESET_CFG;
      target_hd = 0;
      last_err = 0;
      integ = 0;
      elapsed = 0;
      budget = 0;
      turning = 0;
      mismatches = 0;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void set_reg(logic [2:0] idx, logic [REG_DATA_WIDTH-1:0] val);
      case (idx)
        REG_KP_GAIN:         regs.kp_gain = val[GAIN_WIDTH-1:0];
        REG_KI_GAIN:         regs.ki_gain = val[GAIN_WIDTH-1:0];
        REG_KD_GAIN:         regs.kd_gain = val[GAIN_WIDTH-1:0];
        REG_POWER_LIMIT:     regs.power_limit = val[LIMIT_WIDTH-1:0];
        REG_ERROR_TOLERANCE: regs.error_tolerance = val[TOL_WIDTH-1:0];
        REG_RATE_TOLERANCE:  regs.rate_tolerance = val[TOL_WIDTH-1:0];
        REG_INTEGRAL_START:  regs.integral_start = val[TOL_WIDTH-1:0];
        REG_INTEGRAL_RANGE:  regs.integral_range = val[RANGE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted item and queues it.
    function void take_item(in_item_t it);
      longint hd;
      longint err;
      longint diff;
      longint total;
      longint pwr;
      longint lim;
      bit done;
      out_item_t want;
      hd = longint'($signed(it.heading));
      pwr = 0;
      if (it.operation == OP_START) begin
        target_hd = longint'($signed(it.target));
        err = target_hd - hd;
        last_err = err;
        integ = 0;
        elapsed = 0;
        if (magnitude(err) < BUDGET_BIG_ERR) begin
          budget = longint'(BUDGET_MIN_MS);
        end else begin
          budget = (magnitude(err) * BUDGET_MS_PER_DEG) >>> 8;
          if (budget > longint'(MS_MAX)) budget = longint'(MS_MAX);
        end
        turning = (err != 0);
        done = !turning;
      end else if (!turning) begin
        done = 1'b1;
      end else begin
        err = target_hd - hd;
        diff = err - last_err;
        elapsed = elapsed + TICK_MS_DEFAULT;
        if (elapsed > longint'(MS_MAX)) elapsed = longint'(MS_MAX);
        done = (magnitude(err) < longint'(regs.error_tolerance) &&
                magnitude(diff) <= longint'(regs.rate_tolerance)) || elapsed > budget;
        // The integral only moves near the target and while inside its range.
        if (magnitude(integ) < longint'(regs.integral_range) &&
            magnitude(err) < longint'(regs.integral_start)) begin
          if (err > 0) integ = integ + INTEG_STEP;
          else if (err < 0) integ = integ - INTEG_STEP;
          if (integ > INTEG_TOP) integ = INTEG_TOP;
          if (integ < INTEG_BOTTOM) integ = INTEG_BOTTOM;
        end
        // A zero error or a change of sign clears it.
        if (err == 0 || last_err == 0 || ((err < 0) != (last_err < 0))) integ = 0;
        last_err = err;
        total = longint'(regs.kp_gain) * err + longint'(regs.kd_gain) * diff
                + (longint'(regs.ki_gain) * integ) / 256;
        pwr = total / 256;
        lim = longint'(regs.power_limit);
        if (pwr > lim) pwr = lim;
        if (pwr < -lim) pwr = -lim;
        if (done) turning = 0;
      end
      want.drive_power = pwr[POWER_WIDTH-1:0];
      want.finished = done;
      expected_power.push_back(want);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_power(out_item_t got);
      out_item_t want;
      if (expected_power.size() == 0) begin
        $error("unexpected result: drive_power %0d finished %0b",
               got.drive_power, got.finished);
        mismatches++;
        return;
      end
      want = expected_power.pop_front();
      if (got.drive_power !== want.drive_power) begin
        $error("drive_power expected %0d actual %0d", want.drive_power, got.drive_power);
        mismatches++;
      end
      if (got.finished !== want.finished) begin
        $error("finished expected %0b actual %0b", want.finished, got.finished);
        mismatches++;
      end
    endfunction
  endclass

  turn_tracker book;
  bit idling_on;
  int hold_req;
  int items_sent;

  turn_pid_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Give up after a generous fixed time.
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // Result side: check accepted items, then choose the stall for the next cycle.
  // A long hold-off is counted here once the main sequence asks for it.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) book.check_power(result);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= idling_on && ($urandom_range(0, 99) < 32);
    end
  end

  function automatic logic signed [HEADING_WIDTH-1:0] clamp_heading(input longint v);
    if (v > HEAD_MAX) v = HEAD_MAX;
    if (v < HEAD_MIN) v = HEAD_MIN;
    return v[HEADING_WIDTH-1:0];
  endfunction

  function automatic in_item_t make_item(input op_t op, input longint tgt, input longint hd);
    in_item_t it;
    it.operation = op;
    it.target = clamp_heading(tgt);
    it.heading = clamp_heading(hd);
    return it;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.kp_gain = 16'($urandom_range(0, 65535));
    c.ki_gain = 16'($urandom_range(0, 65535));
    c.kd_gain = 16'($urandom_range(0, 65535));
    c.power_limit = 15'($urandom_range(0, 25600));
    c.error_tolerance = 16'($urandom_range(0, 1024));
    c.rate_tolerance = 16'($urandom_range(0, 256));
    c.integral_start = 16'($urandom_range(0, 65535));
    c.integral_range = 18'($urandom_range(0, 131072));
    return c;
  endfunction

  // Offers one item, sometimes after a random gap, and notes it once accepted.
  task automatic send_item(input in_item_t it);
    if (idling_on && $urandom_range(0, 99) < 32) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    book.take_item(it);
    items_sent++;
  endtask

  // Writes a register in a setup and an access phase, then reads it back.
  task automatic reg_write(input logic [2:0] idx, input logic [REG_DATA_WIDTH-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) begin
      $error("register %0d expected %0h actual %0h", idx, val, prdata);
      book.mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    book.set_reg(idx, val);
  endtask

  task automatic load_config(input cfg_t c);
    reg_write(REG_KP_GAIN, REG_DATA_WIDTH'(c.kp_gain));
    reg_write(REG_KI_GAIN, REG_DATA_WIDTH'(c.ki_gain));
    reg_write(REG_KD_GAIN, REG_DATA_WIDTH'(c.kd_gain));
    reg_write(REG_POWER_LIMIT, REG_DATA_WIDTH'(c.power_limit));
    reg_write(REG_ERROR_TOLERANCE, REG_DATA_WIDTH'(c.error_tolerance));
    reg_write(REG_RATE_TOLERANCE, REG_DATA_WIDTH'(c.rate_tolerance));
    reg_write(REG_INTEGRAL_START, REG_DATA_WIDTH'(c.integral_start));
    reg_write(REG_INTEGRAL_RANGE, REG_DATA_WIDTH'(c.integral_range));
  endtask

  // Stops offering items until every expected result has come, then lets the block settle.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (book.expected_power.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One turn: a start and a run of ticks that converge, stick or wander.
  task automatic run_turn();
    longint tgt;
    longint err;
    int mode;
    int ticks;
    case ($urandom_range(0, 7))
      0: tgt = HEAD_MAX;
      1: tgt = HEAD_MIN;
      2, 3: tgt = longint'($urandom_range(0, 1048575)) + HEAD_MIN;
      default: tgt = longint'($urandom_range(0, 92160)) - 46080;
    endcase
    mode = $urandom_range(0, 9);
    if (mode >= 6 && mode < 8) begin
      // Stuck near the target: runs into the time budget.
      err = longint'($urandom_range(1, 5119));
      ticks = $urandom_range(60, 80);
    end else begin
      case ($urandom_range(0, 15))
        0: err = 0;
        1, 2: err = 5119 + longint'($urandom_range(0, 2));
        3, 4, 5: err = longint'($urandom_range(1, 5119));
        6, 7: err = longint'($urandom_range(0, 1048575));
        default: err = longint'($urandom_range(0, 46080));
      endcase
      ticks = (mode >= 8) ? $urandom_range(1, 20) : $urandom_range(5, 60);
    end
    if ($urandom_range(0, 1)) err = -err;
    send_item(make_item(OP_START, tgt, tgt - err));
    repeat (ticks) begin
      if (mode < 6) begin
        err = err * longint'($urandom_range(3, 7)) / 8;
        if ($urandom_range(0, 9) == 0) err = -err / 2;
        if ($urandom_range(0, 19) == 0) err = 0;
        else err = err + longint'($urandom_range(0, 16)) - 8;
      end else if (mode < 8) begin
        err = err + longint'($urandom_range(0, 8)) - 4;
      end else begin
        err = longint'($urandom_range(0, 8192)) - 4096;
      end
      send_item(make_item(OP_TICK, tgt, tgt - err));
    end
  endtask

  // Mostly well-formed turns, with some entirely random items mixed in.
  task automatic random_phase(input int quota);
    int first;
    in_item_t junk;
    first = items_sent;
    while (items_sent - first < quota) begin
      if ($urandom_range(0, 99) < 15) begin
        junk.operation = op_t'($urandom_range(0, 1));
        junk.target = HEADING_WIDTH'($urandom);
        junk.heading = HEADING_WIDTH'($urandom);
        send_item(junk);
      end else begin
        run_turn();
      end
    end
  endtask

  // Main sequence.
  initial begin
    cfg_t c;
    book = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idling_on = 1'b1;
    hold_req = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items, with a visible integral gain.
    c = RESET_CFG;
    c.ki_gain = 16'd4096;
    load_config(c);
    // Tick before any turn, then a start already on target.
    send_item(make_item(OP_TICK, 0, 0));
    send_item(make_item(OP_START, 1000, 1000));
    send_item(make_item(OP_TICK, 1000, 0));
    // Largest errors of both signs drive the power into its clamp.
    send_item(make_item(OP_START, HEAD_MAX, HEAD_MIN));
    send_item(make_item(OP_TICK, 0, HEAD_MIN));
    send_item(make_item(OP_START, HEAD_MIN, HEAD_MAX));
    send_item(make_item(OP_TICK, 0, HEAD_MAX));
    send_item(make_item(OP_TICK, 0, HEAD_MIN));
    // Budget either side of twenty degrees.
    send_item(make_item(OP_START, 0, -5119));
    send_item(make_item(OP_START, 0, -5120));
    send_item(make_item(OP_START, 0, 5120));
    // Sign change of the error, then a finish inside tolerance.
    send_item(make_item(OP_TICK, 0, 5120));
    send_item(make_item(OP_TICK, 0, -100));
    send_item(make_item(OP_TICK, 0, -100));
    send_item(make_item(OP_TICK, 0, -100));
    // Finish on the very first tick.
    send_item(make_item(OP_START, 0, -200));
    send_item(make_item(OP_TICK, 0, -200));
    // A converging turn that builds up the integral.
    send_item(make_item(OP_START, 3000, 0));
    send_item(make_item(OP_TICK, 0, 2000));
    send_item(make_item(OP_TICK, 0, 2900));
    send_item(make_item(OP_TICK, 0, 2990));
    send_item(make_item(OP_TICK, 0, 2999));
    send_item(make_item(OP_TICK, 0, 2999));
    drain();

    // Random phases under several register settings.
    load_config(RESET_CFG);
    random_phase(PHASE_ITEMS);
    drain();

    load_config(random_cfg());
    random_phase(PHASE_ITEMS);
    drain();

    // No idling at all, and a long hold-off on the result side at the start.
    idling_on = 1'b0;
    load_config(MAX_CFG);
    hold_req++;
    random_phase(PHASE_ITEMS);
    drain();
    idling_on = 1'b1;

    load_config('0);
    random_phase(PHASE_ITEMS);
    drain();

    c = random_cfg();
    c.ki_gain = 16'($urandom_range(1000, 20000));
    c.error_tolerance = 16'd256;
    c.rate_tolerance = 16'd26;
    load_config(c);
    random_phase(PHASE_ITEMS);
    drain();

    load_config(random_cfg());
    random_phase(PHASE_ITEMS);
    drain();

    if (book.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
